// ===== rtl/core/edt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package edt_pkg;

	localparam int TOKEN_COUNT_BITS_DEF = 16;
	localparam int TOKEN_NUMBER_W       = 16;
	localparam int MASK_REGS            = 8;
	localparam int MASK_REG_W           = 32;
	localparam int CFG_INDEX_W          = $clog2(MASK_REGS);
	localparam int CMD_QUEUE_DEPTH      = 4;
	localparam int HEX_STEPS            = 6;
	localparam int STEP_W               = $clog2(HEX_STEPS);

	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_EOT  = 2'd1;
	localparam logic [1:0] KIND_EOS  = 2'd2;

	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_LBRACKET  = 8'h5b;
	localparam logic [7:0] CH_RBRACKET  = 8'h5d;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_X         = 8'h78;

	typedef enum logic [2:0] {
		OP_CHAR,
		OP_HEX,
		OP_EOT,
		OP_EOS,
		OP_EOS_CLOSE
	} op_t;

	// One command per input byte that produces results.
	typedef struct packed {
		op_t                        op;
		logic [7:0]                 ch;
		logic [TOKEN_NUMBER_W-1:0]  tok_a;
		logic [TOKEN_NUMBER_W-1:0]  tok_b;
	} cmd_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] wide;
		wide = {4'd0, nib};
		if (nib < 4'd10) begin
			hex_char = CH_ZERO + wide;
		end else begin
			hex_char = 8'h61 + wide - 8'd10;
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/edt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module edt_front #(
	parameter int TOKEN_COUNT_BITS = edt_pkg::TOKEN_COUNT_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               push,
	input  wire logic                               full,
	input  wire logic [7:0]                         in_byte,
	input  wire logic                               cfg_we,
	input  wire logic [edt_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [edt_pkg::MASK_REG_W-1:0]     cfg_data,
	output      logic                               cmd_push,
	output      edt_pkg::cmd_t                      cmd
);

	localparam int MASK_BITS = edt_pkg::MASK_REGS * edt_pkg::MASK_REG_W;

	logic [edt_pkg::MASK_REG_W-1:0] mask_q [edt_pkg::MASK_REGS];
	logic [MASK_BITS-1:0]           mask_flat;
	logic                           esc_q, esc_d;
	logic                           open_q, open_d;
	logic [TOKEN_COUNT_BITS-1:0]    cnt_q, cnt_d, cnt_inc;
	logic [7:0]                     dec;
	logic                           have_byte;
	logic                           accept;

	function automatic logic [7:0] decode_escape(input logic [7:0] b);
		unique case (b)
			8'h6e:   decode_escape = 8'h0a;
			8'h74:   decode_escape = 8'h09;
			8'h76:   decode_escape = 8'h0b;
			8'h62:   decode_escape = 8'h08;
			8'h72:   decode_escape = 8'h0d;
			8'h66:   decode_escape = 8'h0c;
			8'h61:   decode_escape = 8'h07;
			default: decode_escape = b;
		endcase
	endfunction

	function automatic logic shown_as_hex(input logic [7:0] d);
		shown_as_hex = (d == 8'h0a) || (d == 8'h09) || (d == 8'h0b) || (d == 8'h08) ||
			(d == 8'h0d) || (d == 8'h0c) || (d == 8'h07) ||
			(d == edt_pkg::CH_BACKSLASH) || (d == edt_pkg::CH_QUOTE);
	endfunction

	always_comb begin
		for (int k = 0; k < edt_pkg::MASK_REGS; k++) begin
			mask_flat[k*edt_pkg::MASK_REG_W +: edt_pkg::MASK_REG_W] = mask_q[k];
		end
	end

	assign accept  = push && !full;
	assign cnt_inc = (cnt_q == {TOKEN_COUNT_BITS{1'b1}}) ? cnt_q : cnt_q + 1'b1;

	always_comb begin
		esc_d     = esc_q;
		open_d    = open_q;
		cnt_d     = cnt_q;
		cmd_push  = 1'b0;
		have_byte = 1'b0;
		dec       = in_byte;
		cmd.op    = edt_pkg::OP_CHAR;
		cmd.ch    = in_byte;
		cmd.tok_a = edt_pkg::TOKEN_NUMBER_W'(cnt_q);
		cmd.tok_b = edt_pkg::TOKEN_NUMBER_W'(cnt_q);
		if (in_byte == edt_pkg::CH_NUL) begin
			cmd_push = 1'b1;
			if (open_q) begin
				cmd.op    = edt_pkg::OP_EOS_CLOSE;
				cmd.tok_b = edt_pkg::TOKEN_NUMBER_W'(cnt_inc);
			end else begin
				cmd.op = edt_pkg::OP_EOS;
			end
			esc_d  = 1'b0;
			open_d = 1'b0;
			cnt_d  = '0;
		end else if (esc_q) begin
			esc_d     = 1'b0;
			dec       = decode_escape(in_byte);
			have_byte = 1'b1;
		end else if (in_byte == edt_pkg::CH_BACKSLASH) begin
			esc_d = 1'b1;
		end else begin
			have_byte = 1'b1;
		end

		if (have_byte) begin
			cmd.ch = dec;
			if (mask_flat[dec]) begin
				if (open_q) begin
					cmd_push = 1'b1;
					cmd.op   = edt_pkg::OP_EOT;
					cnt_d    = cnt_inc;
					open_d   = 1'b0;
				end
			end else begin
				cmd_push = 1'b1;
				open_d   = 1'b1;
				cmd.op   = shown_as_hex(dec) ? edt_pkg::OP_HEX : edt_pkg::OP_CHAR;
			end
		end

		if (!accept) begin
			cmd_push = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q  <= 1'b0;
			open_q <= 1'b0;
			cnt_q  <= '0;
			for (int k = 0; k < edt_pkg::MASK_REGS; k++) begin
				mask_q[k] <= '0;
			end
		end else begin
			if (accept) begin
				esc_q  <= esc_d;
				open_q <= open_d;
				cnt_q  <= cnt_d;
			end
			if (cfg_we) begin
				mask_q[cfg_index] <= cfg_data;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/edt_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module edt_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire edt_pkg::cmd_t  wr_cmd,
	input  wire logic           rd_en,
	output      logic           full,
	output      logic           head_valid,
	output      edt_pkg::cmd_t  head_cmd
);

	localparam int ADDR_W = $clog2(edt_pkg::CMD_QUEUE_DEPTH);

	edt_pkg::cmd_t   mem_q [edt_pkg::CMD_QUEUE_DEPTH];
	logic [ADDR_W:0] wr_ptr_q;
	logic [ADDR_W:0] rd_ptr_q;

	// Pointers carry one extra bit so that full and empty differ.
	assign full       = (wr_ptr_q[ADDR_W] != rd_ptr_q[ADDR_W]) &&
		(wr_ptr_q[ADDR_W-1:0] == rd_ptr_q[ADDR_W-1:0]);
	assign head_valid = (wr_ptr_q != rd_ptr_q);
	assign head_cmd   = mem_q[rd_ptr_q[ADDR_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q[ADDR_W-1:0]] <= wr_cmd;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/edt_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module edt_back (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 head_valid,
	input  wire edt_pkg::cmd_t                        head_cmd,
	input  wire logic                                 pop,
	output      logic                                 head_done,
	output      logic                                 empty,
	output      logic [1:0]                           out_kind,
	output      logic [7:0]                           out_char,
	output      logic [edt_pkg::TOKEN_NUMBER_W-1:0]   token_number,
	output      logic                                 last
);

	logic [edt_pkg::STEP_W-1:0]          step_q;
	logic                                out_valid_q;
	logic [1:0]                          kind_q;
	logic [7:0]                          char_q;
	logic [edt_pkg::TOKEN_NUMBER_W-1:0]  tok_q;
	logic                                last_q;
	logic [1:0]                          res_kind;
	logic [7:0]                          res_char;
	logic [edt_pkg::TOKEN_NUMBER_W-1:0]  res_tok;
	logic                                res_last;
	logic                                load;

	always_comb begin
		res_kind = edt_pkg::KIND_CHAR;
		res_char = head_cmd.ch;
		res_tok  = head_cmd.tok_a;
		res_last = 1'b1;
		unique case (head_cmd.op)
			edt_pkg::OP_CHAR: begin
			end
			edt_pkg::OP_HEX: begin
				res_last = (step_q == edt_pkg::STEP_W'(edt_pkg::HEX_STEPS - 1));
				unique case (step_q)
					3'd0:    res_char = edt_pkg::CH_LBRACKET;
					3'd1:    res_char = edt_pkg::CH_ZERO;
					3'd2:    res_char = edt_pkg::CH_X;
					3'd3:    res_char = edt_pkg::hex_char(head_cmd.ch[7:4]);
					3'd4:    res_char = edt_pkg::hex_char(head_cmd.ch[3:0]);
					default: res_char = edt_pkg::CH_RBRACKET;
				endcase
			end
			edt_pkg::OP_EOT: begin
				res_kind = edt_pkg::KIND_EOT;
				res_char = '0;
			end
			edt_pkg::OP_EOS: begin
				res_kind = edt_pkg::KIND_EOS;
				res_char = '0;
			end
			edt_pkg::OP_EOS_CLOSE: begin
				// The open token closes first, then the string ends.
				res_char = '0;
				if (step_q == '0) begin
					res_kind = edt_pkg::KIND_EOT;
					res_last = 1'b0;
				end else begin
					res_kind = edt_pkg::KIND_EOS;
					res_tok  = head_cmd.tok_b;
				end
			end
			default: begin
				res_kind = edt_pkg::KIND_EOS;
				res_char = '0;
			end
		endcase
	end

	assign load      = head_valid && (!out_valid_q || pop);
	assign head_done = load && res_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			step_q      <= res_last ? '0 : step_q + 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= res_kind;
			char_q <= res_char;
			tok_q  <= res_tok;
			last_q <= res_last;
		end
	end

	assign empty        = !out_valid_q;
	assign out_kind     = kind_q;
	assign out_char     = char_q;
	assign token_number = tok_q;
	assign last         = last_q;

endmodule

`default_nettype wire

// ===== rtl/core/escaped_delimiter_tokenizer_core.sv =====
// Path: an accepted byte enters the command queue, then the output register.
// Throughput: one byte per cycle while full is low; a byte shown as [0xhh] holds the result
// sequencer for six results and a string end that closes a token for two. The four-entry
// command queue absorbs these bursts; the sequencer emits one result a cycle while pop is high.
// Reset: arst_n clears tokenizer state, delimiter masks, queue and output register at once.
`timescale 1ns / 1ps
`default_nettype none

module escaped_delimiter_tokenizer_core #(
	parameter int TOKEN_COUNT_BITS = edt_pkg::TOKEN_COUNT_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 push,
	output      logic                                 full,
	input  wire logic [7:0]                           in_byte,
	output      logic                                 empty,
	input  wire logic                                 pop,
	output      logic [1:0]                           out_kind,
	output      logic [7:0]                           out_char,
	output      logic [edt_pkg::TOKEN_NUMBER_W-1:0]   token_number,
	output      logic                                 last,
	input  wire logic                                 cfg_we,
	input  wire logic [edt_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire logic [edt_pkg::MASK_REG_W-1:0]       cfg_data
);

	logic           cmd_push;
	edt_pkg::cmd_t  cmd;
	logic           head_valid;
	edt_pkg::cmd_t  head_cmd;
	logic           head_done;

	edt_front #(
		.TOKEN_COUNT_BITS(TOKEN_COUNT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_byte   (in_byte),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_push  (cmd_push),
		.cmd       (cmd)
	);

	edt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (cmd_push),
		.wr_cmd     (cmd),
		.rd_en      (head_done),
		.full       (full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	edt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_cmd     (head_cmd),
		.pop          (pop),
		.head_done    (head_done),
		.empty        (empty),
		.out_kind     (out_kind),
		.out_char     (out_char),
		.token_number (token_number),
		.last         (last)
	);

endmodule

`default_nettype wire

// ===== rtl/core/edt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module edt_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                empty,
	input wire logic                                pop,
	input wire logic [1:0]                          out_kind,
	input wire logic [7:0]                          out_char,
	input wire logic [edt_pkg::TOKEN_NUMBER_W-1:0]  token_number,
	input wire logic                                last
);

	// An end of string is always the final result of its byte.
	a_eos_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_kind == edt_pkg::KIND_EOS) |-> last)
		else $error("end of string without last");

	// Markers carry no character.
	a_marker_char: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_kind != edt_pkg::KIND_CHAR) |-> (out_char == 8'd0))
		else $error("marker with nonzero character");

	// A token end that is not last belongs to a string end, which follows at once.
	a_close_then_eos: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && out_kind == edt_pkg::KIND_EOT && !last) |=>
		(!empty && out_kind == edt_pkg::KIND_EOS))
		else $error("token end not followed by string end");

	// A waiting result holds until its transfer.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_kind) && $stable(out_char) &&
		$stable(token_number) && $stable(last)))
		else $error("result changed while stalled");

endmodule

bind escaped_delimiter_tokenizer_core edt_checker u_edt_checker (.*);

`default_nettype wire
